// ===== hw/rtl/dh_link_transform_assert.svh =====
// Assertion macros shared by the DH link transform RTL.
// Plain concurrent assertions clocked on clk, disabled during rst.
`ifndef DH_LINK_TRANSFORM_ASSERT_SVH
`define DH_LINK_TRANSFORM_ASSERT_SVH

// Antecedent implies consequent on the next clock edge.
`define DHL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhl assertion failed");

// Antecedent implies consequent on the same clock edge.
`define DHL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhl assertion failed");

`endif

// ===== hw/rtl/dhl_pkg.sv =====
// Shared constants and helpers for the DH link transform.
// No dependencies.
`default_nettype none
package dhl_pkg;
  localparam int TrigStages = 16;
  localparam int PipeDepth = TrigStages + 4;

  localparam logic signed [33:0] Q30Pi = 34'sd3373259426;
  localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [15:0] NegOneQ14 = -16'sd16384;

  localparam logic CONV_CLASSIC = 1'b0;
  localparam logic CONV_CRAIG = 1'b1;

  function automatic logic signed [33:0] atan_q30(input int idx);
    logic signed [33:0] v;
    case (idx)
      0: v = 34'sh3243F6A8;
      1: v = 34'sh1DAC6705;
      2: v = 34'sh0FADBAFC;
      3: v = 34'sh07F56EA6;
      4: v = 34'sh03FEAB76;
      5: v = 34'sh01FFD55B;
      6: v = 34'sh00FFFAAA;
      7: v = 34'sh007FFF55;
      8: v = 34'sh003FFFEA;
      9: v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      24: v = 34'sh0000003F;
      25: v = 34'sh0000001F;
      26: v = 34'sh0000000F;
      27: v = 34'sh00000007;
      28: v = 34'sh00000003;
      29: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
    if (v > 34'sd16384) return OneQ14;
    if (v < -34'sd16384) return NegOneQ14;
    return v[15:0];
  endfunction

  // Q2.14 times Q2.14, round half up, clamp
  function automatic logic signed [15:0] mul_rot(input logic signed [15:0] p,
                                                 input logic signed [15:0] q);
    logic signed [33:0] pr;
    pr = (34'(p) * 34'(q) + 34'sd8192) >>> 14;
    return clamp_q14(pr);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/dh_link_transform.sv =====
// DH link transform: 16-stage CORDIC per angle, product, saturate, output.
// One word per cycle whenever the output word is not held.
// Whole pipe advances together and stalls only when the output word is held.
// Reset (rst, synchronous) clears all valid bits and convention to classic.
// Depends on dhl_pkg and dh_link_transform_assert.svh.
`default_nettype none
module dh_link_transform
  import dhl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] twist_angle,
  input  wire logic signed [31:0] link_length,
  input  wire logic signed [31:0] link_offset,
  input  wire logic signed [15:0] joint_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      rot_00,
  output logic signed [15:0]      rot_01,
  output logic signed [15:0]      rot_02,
  output logic signed [15:0]      rot_10,
  output logic signed [15:0]      rot_11,
  output logic signed [15:0]      rot_12,
  output logic signed [15:0]      rot_20,
  output logic signed [15:0]      rot_21,
  output logic signed [15:0]      rot_22,
  output logic signed [31:0]      trans_x,
  output logic signed [31:0]      trans_y,
  output logic signed [31:0]      trans_z
);
  `include "dh_link_transform_assert.svh"

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  logic convention;
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) convention <= CONV_CLASSIC;
    else if (cfg_we) convention <= cfg_wdata;
  end

  // stage 0: range reduction
  logic [PipeDepth-1:0] vld;
  cordic_t ca_st [0:TrigStages];
  cordic_t ct_st [0:TrigStages];
  logic signed [31:0] len_d [0:TrigStages];
  logic signed [31:0] off_d [0:TrigStages];

  function automatic cordic_t reduce(input logic signed [15:0] ang);
    cordic_t r;
    logic signed [33:0] z;
    z = 34'(ang) <<< 17;
    r.flip = 1'b0;
    if (z > Q30HalfPi) begin
      z = z - Q30Pi;
      r.flip = 1'b1;
    end else if (z < -Q30HalfPi) begin
      z = z + Q30Pi;
      r.flip = 1'b1;
    end
    r.x = CordicGain;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  function automatic cordic_t rot_step(input cordic_t c, input int i);
    cordic_t r;
    r = c;
    if (!c.z[33]) begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - atan_q30(i);
    end else begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + atan_q30(i);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[PipeDepth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca_st[0] <= reduce(twist_angle);
      ct_st[0] <= reduce(joint_angle);
      len_d[0] <= link_length;
      off_d[0] <= link_offset;
    end
  end

  for (genvar g = 0; g < TrigStages; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        ca_st[g+1] <= rot_step(ca_st[g], g);
        ct_st[g+1] <= rot_step(ct_st[g], g);
        len_d[g+1] <= len_d[g];
        off_d[g+1] <= off_d[g];
      end
    end
  end

  function automatic logic signed [15:0] fin(input logic signed [33:0] v,
                                             input logic flip);
    logic signed [15:0] r;
    r = clamp_q14((v + 34'sd32768) >>> 16);
    return flip ? -r : r;
  endfunction

  // trig finish
  logic signed [15:0] sa, ca, st, ct;
  logic signed [31:0] len_t, off_t;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa <= fin(ca_st[TrigStages].y, ca_st[TrigStages].flip);
      ca <= fin(ca_st[TrigStages].x, ca_st[TrigStages].flip);
      st <= fin(ct_st[TrigStages].y, ct_st[TrigStages].flip);
      ct <= fin(ct_st[TrigStages].x, ct_st[TrigStages].flip);
      len_t <= len_d[TrigStages];
      off_t <= off_d[TrigStages];
    end
  end

  // products: rotation terms rounded and clamped, length terms raw, registered before rounding
  logic signed [15:0] sa2, ca2, st2, ct2;
  logic signed [15:0] p_stca, p_stsa, p_ctca, p_ctsa;
  logic signed [47:0] p_ac, p_as, p_ds, p_dc;
  logic signed [31:0] len2, off2;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa2 <= sa; ca2 <= ca; st2 <= st; ct2 <= ct;
      p_stca <= mul_rot(st, ca);
      p_stsa <= mul_rot(st, sa);
      p_ctca <= mul_rot(ct, ca);
      p_ctsa <= mul_rot(ct, sa);
      p_ac <= 48'(len_t) * 48'(ct);
      p_as <= 48'(len_t) * 48'(st);
      p_ds <= 48'(off_t) * 48'(sa);
      p_dc <= 48'(off_t) * 48'(ca);
      len2 <= len_t;
      off2 <= off_t;
    end
  end

  function automatic logic signed [31:0] rnd_len(input logic signed [47:0] p);
    logic signed [48:0] r;
    r = (49'(p) + 49'sd8192) >>> 14;
    return sat32(r);
  endfunction

  // saturate first, then negate; the most negative value flips to the max
  function automatic logic signed [31:0] neg_rnd_len(input logic signed [47:0] p);
    logic signed [48:0] r;
    r = 49'(rnd_len(p));
    return sat32(-r);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      if (convention == CONV_CLASSIC) begin
        rot_00 <= ct2; rot_01 <= -p_stca; rot_02 <= p_stsa;
        rot_10 <= st2; rot_11 <= p_ctca;  rot_12 <= -p_ctsa;
        rot_20 <= '0;  rot_21 <= sa2;     rot_22 <= ca2;
        trans_x <= rnd_len(p_ac);
        trans_y <= rnd_len(p_as);
        trans_z <= off2;
      end else begin
        rot_00 <= ct2;    rot_01 <= -st2;   rot_02 <= '0;
        rot_10 <= p_stca; rot_11 <= p_ctca; rot_12 <= -sa2;
        rot_20 <= p_stsa; rot_21 <= p_ctsa; rot_22 <= ca2;
        trans_x <= len2;
        trans_y <= neg_rnd_len(p_ds);
        trans_z <= rnd_len(p_dc);
      end
    end
  end

  assign out_valid = vld[PipeDepth-1];

  `DHL_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(trans_x))
  `DHL_ASSERT_SAME(a_ready_rule, !in_ready, out_valid && !out_ready)
  `DHL_ASSERT_NEXT(a_valid_shift, adv && in_valid, vld[0])
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for dh_link_transform: directed table, then random link words,
// checked as whole frames against an in-bench fixed-point DH predictor.
// Depends on dhl_pkg and the dh_link_transform RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import dhl_pkg::*;

  localparam int Stages = 16;
  localparam int LatencyCycles = 20;
  localparam longint Q30PiL = 64'sd3373259426;
  localparam longint Q30HalfPiL = 64'sd1686629713;
  localparam longint GainL = 64'sd652032874;

  typedef struct packed {
    logic signed [15:0] twist;
    logic signed [31:0] len;
    logic signed [31:0] offs;
    logic signed [15:0] joint;
  } link_t;

  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] tx, ty, tz;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  link_t link_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frame_t got;

  logic conv_sel = CONV_CLASSIC;
  frame_t frames_due[$];
  int errors = 0;
  bit quiet = 1'b0;

  dh_link_transform dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .twist_angle(link_word.twist), .link_length(link_word.len),
    .link_offset(link_word.offs), .joint_angle(link_word.joint),
    .out_valid(out_valid), .out_ready(out_ready),
    .rot_00(got.r00), .rot_01(got.r01), .rot_02(got.r02),
    .rot_10(got.r10), .rot_11(got.r11), .rot_12(got.r12),
    .rot_20(got.r20), .rot_21(got.r21), .rot_22(got.r22),
    .trans_x(got.tx), .trans_y(got.ty), .trans_z(got.tz)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint t[32] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003,
      64'h00000001, 64'h0, 64'h0};
    return t[i];
  endfunction

  task automatic angle_sincos(input logic signed [15:0] ang,
                              output longint s, output longint c);
    longint z, x, y, nx, ny;
    bit flip;
    z = longint'(ang) * 131072;
    x = GainL;
    y = 0;
    flip = 1'b0;
    if (z > Q30HalfPiL) begin
      z -= Q30PiL;
      flip = 1'b1;
    end else if (z < -Q30HalfPiL) begin
      z += Q30PiL;
      flip = 1'b1;
    end
    for (int i = 0; i < Stages && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i);
        ny = y + sra(x, i);
        z -= atan_step(i);
      end else begin
        nx = x + sra(y, i);
        ny = y - sra(x, i);
        z += atan_step(i);
      end
      x = nx;
      y = ny;
    end
    x = clip(sra(x + 32768, 16), -16384, 16384);
    y = clip(sra(y + 32768, 16), -16384, 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint rot_prod(longint p, longint q);
    return clip(sra(p * q + 8192, 14), -16384, 16384);
  endfunction

  function automatic longint len_prod(longint l, longint q);
    return clip(sra(l * q + 8192, 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  task automatic link_frame(input link_t w, input logic conv, output frame_t f);
    longint sa, ca, st, ct, a, d;
    angle_sincos(w.twist, sa, ca);
    angle_sincos(w.joint, st, ct);
    a = longint'(w.len);
    d = longint'(w.offs);
    if (conv == CONV_CLASSIC) begin
      f.r00 = 16'(ct); f.r01 = 16'(-rot_prod(st, ca)); f.r02 = 16'(rot_prod(st, sa));
      f.r10 = 16'(st); f.r11 = 16'(rot_prod(ct, ca));  f.r12 = 16'(-rot_prod(ct, sa));
      f.r20 = '0;      f.r21 = 16'(sa);                f.r22 = 16'(ca);
      f.tx = 32'(len_prod(a, ct));
      f.ty = 32'(len_prod(a, st));
      f.tz = 32'(d);
    end else begin
      f.r00 = 16'(ct);               f.r01 = 16'(-st);              f.r02 = '0;
      f.r10 = 16'(rot_prod(st, ca)); f.r11 = 16'(rot_prod(ct, ca)); f.r12 = 16'(-sa);
      f.r20 = 16'(rot_prod(st, sa)); f.r21 = 16'(rot_prod(ct, sa)); f.r22 = 16'(ca);
      f.tx = 32'(a);
      f.ty = 32'(clip(-len_prod(d, sa), -64'sd2147483648, 64'sd2147483647));
      f.tz = 32'(len_prod(d, ca));
    end
  endtask

  // result side: random stalls, checked on accept
  always @(posedge clk) begin
    frame_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t unexpected word: got %h", $time, got);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (want !== got) begin
            $display("%0t mismatch: expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  // valid stays high between back-to-back words; it drops only when idling
  task automatic send_link(input link_t w, input bit has_want, input frame_t want);
    frame_t f;
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    link_frame(w, conv_sel, f);
    if (has_want && f !== want) begin
      $display("%0t table row disagrees: expected %h predicted %h", $time, want, f);
      errors++;
    end
    frames_due.push_back(f);
    in_valid <= 1'b1;
    link_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_and_set(input logic conv);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= conv;
    conv_sel = conv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'(int'($urandom_range(25736)) - 12868); // within +-pi/2
      default: return 16'(int'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_len();
    if ($urandom_range(4) == 0) return $urandom();
    return 32'(int'($urandom_range(32'h00200000)) - 32'sh00100000);
  endfunction

  typedef struct {
    link_t w;
    bit has_want;
    frame_t want;
  } row_t;

  row_t table_rows[$];
  link_t w;
  frame_t zero_f, none;

  initial begin
    // zero angles, zero lengths, classic: identity rotation
    zero_f = '{r00: 16384, r11: 16384, r22: 16384, default: '0};
    none = '0;
    table_rows.push_back('{'{16'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b1, zero_f});
    table_rows.push_back('{'{16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF}, 0, none});
    table_rows.push_back('{'{16'sh8000, 32'sh80000000, 32'sh80000000, 16'sh8000}, 0, none});
    table_rows.push_back('{'{16'sh7FFF, 32'sh80000000, 32'sh7FFFFFFF, 16'sh8000}, 0, none});
    table_rows.push_back('{'{16'sd12868, 32'sh00010000, 32'sh00010000, 16'sd12868}, 0, none});
    table_rows.push_back('{'{16'sd12869, 32'sh7FFFFFFF, 32'sh80000000, 16'sd12869}, 0, none});
    table_rows.push_back('{'{-16'sd12868, 32'sh80000000, 32'sh7FFFFFFF, -16'sd12869}, 0, none});
    table_rows.push_back('{'{16'sd25736, 32'sh00010000, 32'shFFFF0000, -16'sd25736}, 0, none});
    table_rows.push_back('{'{16'sd6434, 32'sh00000001, 32'shFFFFFFFF, -16'sd6434}, 0, none});
    table_rows.push_back('{'{16'shFFFF, 32'shFFFFFFFF, 32'sh00000001, 16'sh0001}, 0, none});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) send_link(table_rows[i].w, table_rows[i].has_want,
                                      table_rows[i].want);
    drain_and_set(CONV_CRAIG);
    foreach (table_rows[i]) send_link(table_rows[i].w, 1'b0, none);

    for (int n = 0; n < 550; n++) begin
      if (n == 150) drain_and_set(CONV_CLASSIC);
      if (n == 300) drain_and_set(CONV_CRAIG);
      if (n == 450) drain_and_set(CONV_CLASSIC);
      quiet = (n >= 200 && n < 280); // back-to-back stretch
      w.twist = rand_angle();
      w.len = rand_len();
      w.offs = rand_len();
      w.joint = rand_angle();
      send_link(w, 1'b0, none);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== dh_link_transform.f =====
+incdir+hw/rtl
hw/rtl/dhl_pkg.sv
hw/rtl/dh_link_transform.sv
test/testbench.sv
